@@ rtl/frwm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// frwm_pkg
// Shared widths, constants and types of the frame rate window meter.
// ----------------------------------------------------------------------------
package frwm_pkg;

   localparam int TS_W        = 32;   // millisecond timestamp and interval width
   localparam int RATE_W      = 22;   // q8 rate width
   localparam int USED_W      = 4;    // samples_used width
   localparam int TDATA_IN_W  = 32;
   localparam int TDATA_OUT_W = 32;
   localparam int WINDOW_DEF  = 10;

   // 1000 ms per second scaled by 2^8 for the q8 result
   localparam int unsigned MS_Q8   = 256000;
   localparam int          MS_Q8_W = 18;

   localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};

   localparam logic OP_START = 1'b0;
   localparam logic OP_FRAME = 1'b1;

   typedef struct packed {
      logic            op;
      logic [TS_W-1:0] interval;
   } frwm_item_type;

endpackage
`default_nettype wire

@@ rtl/frame_rate_window_meter.sv @@
`default_nettype none
// path: a word passes the two-entry queue into the back; a frame word then
//    runs idle, read, update, divide and done, a start word idle, clear and
//    done, before the response register is loaded
// throughput: one word at a time in the back; the serial divider yields one
//    quotient bit per cycle; the two-entry queue takes words meanwhile
// reset: synchronous, clears timestamp, ring valid bits, sum, count and queue
// ----------------------------------------------------------------------------
// frame_rate_window_meter
// Moving-average frame rate meter over the last WINDOW frame intervals,
// reporting 1000 * count / sum frames per second in unsigned q8.
// ----------------------------------------------------------------------------
module frame_rate_window_meter
   import frwm_pkg::*;
#(
   parameter int WINDOW = WINDOW_DEF
)
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [TDATA_IN_W-1:0]  req_tdata,   // timestamp_ms[31:0]
   input  wire logic                   req_tuser,   // op
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [TDATA_OUT_W-1:0]      rsp_tdata,   // rate_q8[21:0], samples_used[25:22]
   output logic                        rsp_tuser    // saturated
);

   localparam int PAD_W = TDATA_OUT_W - RATE_W - USED_W;

   logic              push_valid;
   logic              push_ready;
   frwm_item_type     push_item;
   logic              pop_valid;
   logic              pop_ready;
   frwm_item_type     pop_item;
   logic [RATE_W-1:0] rsp_rate;
   logic [USED_W-1:0] rsp_used;

   frwm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   frwm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   frwm_back #(
      .WINDOW (WINDOW)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item  (pop_item),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_rate  (rsp_rate),
      .rsp_used  (rsp_used),
      .rsp_sat   (rsp_tuser)
   );

   assign rsp_tdata = {{PAD_W{1'b0}}, rsp_used, rsp_rate};

endmodule
`default_nettype wire

@@ rtl/frwm_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// frwm_front
// Accepts request words, forms the wrapped interval to the previous
// timestamp and hands op and interval to the queue.
// ----------------------------------------------------------------------------
module frwm_front
   import frwm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [TDATA_IN_W-1:0] req_tdata,   // timestamp_ms[31:0]
   input  wire logic                  req_tuser,   // op
   output logic                       push_valid,
   input  wire logic                  push_ready,
   output frwm_item_type              push_item
);

   logic [TS_W-1:0] last_time_ff;
   logic [TS_W-1:0] last_time_in;
   logic [TS_W-1:0] now;
   logic            accept;

   assign now        = req_tdata[TS_W-1:0];
   assign accept     = req_tvalid && push_ready;
   assign req_tready = push_ready;
   assign push_valid = req_tvalid;

   // difference wraps modulo 2^32, only frame words use it
   assign push_item.op       = req_tuser;
   assign push_item.interval = now - last_time_ff;

   always_comb begin
      last_time_in = last_time_ff;
      if (accept) begin
         last_time_in = now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_time_ff <= '0;
      end else begin
         last_time_ff <= last_time_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/frwm_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// frwm_queue
// Two-entry queue between the front and the back of the meter.
// ----------------------------------------------------------------------------
module frwm_queue
   import frwm_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push_valid,
   output logic               push_ready,
   input  wire frwm_item_type push_item,
   output logic               pop_valid,
   input  wire logic          pop_ready,
   output frwm_item_type      pop_item
);

   localparam int DEPTH = 2;

   frwm_item_type entry_ff [DEPTH];
   logic          wr_ptr_ff;
   logic          wr_ptr_in;
   logic          rd_ptr_ff;
   logic          rd_ptr_in;
   logic [1:0]    count_ff;
   logic [1:0]    count_in;
   logic          do_push;
   logic          do_pop;

   assign push_ready = (count_ff != 2'(DEPTH));
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

@@ rtl/frwm_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// frwm_back
// Interval ring, running sum and serial restoring divider; produces the
// q8 rate, the sample count and the saturation flag into an output register.
// ----------------------------------------------------------------------------
module frwm_back
   import frwm_pkg::*;
#(
   parameter int WINDOW = WINDOW_DEF
)
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          pop_valid,
   output logic               pop_ready,
   input  wire frwm_item_type pop_item,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output logic [RATE_W-1:0]  rsp_rate,
   output logic [USED_W-1:0]  rsp_used,
   output logic               rsp_sat
);

   localparam int SLOT_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W     = $clog2(WINDOW + 1);
   localparam int SUM_W     = TS_W + ((WINDOW > 1) ? $clog2(WINDOW) : 0);
   localparam int NUM_W     = MS_Q8_W + CNT_W;
   localparam int DIV_CNT_W = $clog2(NUM_W);
   localparam int CMP_W     = (NUM_W > RATE_W) ? NUM_W : RATE_W;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_READ   = 6'b000010,
      S_CLEAR  = 6'b000100,
      S_UPDATE = 6'b001000,
      S_DIV    = 6'b010000,
      S_DONE   = 6'b100000
   } state_type;

   state_type              state_ff,    state_in;
   logic                   op_ff,       op_in;
   logic [TS_W-1:0]        interval_ff, interval_in;
   logic [WINDOW-1:0]      valid_ff,    valid_in;
   logic [SLOT_W-1:0]      slot_ff,     slot_in;
   logic [CNT_W-1:0]       cnt_ff,      cnt_in;
   logic [SUM_W-1:0]       sum_ff,      sum_in;
   logic [NUM_W-1:0]       num_ff,      num_in;
   logic [SUM_W-1:0]       rem_ff,      rem_in;
   logic [NUM_W-1:0]       quo_ff,      quo_in;
   logic [DIV_CNT_W-1:0]   div_cnt_ff,  div_cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RATE_W-1:0]      rsp_rate_ff, rsp_rate_in;
   logic [USED_W-1:0]      rsp_used_ff, rsp_used_in;
   logic                   rsp_sat_ff,  rsp_sat_in;

   logic [TS_W-1:0]        ring_mem [WINDOW];
   logic [TS_W-1:0]        rd_data_ff;

   logic [TS_W-1:0]        old_val;
   logic [CNT_W-1:0]       cnt_next;
   logic [SUM_W:0]         rem_shift;
   logic                   rem_ge;
   logic                   res_sat;
   logic                   load;

   assign pop_ready = (state_ff == S_IDLE);
   assign load      = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   // entries never written since the last clear read as zero
   assign old_val  = valid_ff[slot_ff] ? rd_data_ff : '0;
   assign cnt_next = (cnt_ff < CNT_W'(WINDOW)) ? cnt_ff + 1'b1 : cnt_ff;

   assign rem_shift = {rem_ff, num_ff[NUM_W-1]};
   assign rem_ge    = (rem_shift >= {1'b0, sum_ff});

   assign res_sat = (sum_ff == '0) || (CMP_W'(quo_ff) > CMP_W'(RATE_MAX));

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      interval_in  = interval_ff;
      valid_in     = valid_ff;
      slot_in      = slot_ff;
      cnt_in       = cnt_ff;
      sum_in       = sum_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      div_cnt_in   = div_cnt_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      rsp_rate_in  = rsp_rate_ff;
      rsp_used_in  = rsp_used_ff;
      rsp_sat_in   = rsp_sat_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (pop_valid) begin
               op_in       = pop_item.op;
               interval_in = pop_item.interval;
               state_in    = (pop_item.op == OP_START) ? S_CLEAR : S_READ;
            end
         end
         S_READ: begin
            state_in = S_UPDATE;
         end
         S_CLEAR: begin
            valid_in = '0;
            slot_in  = '0;
            cnt_in   = '0;
            sum_in   = '0;
            state_in = S_DONE;
         end
         S_UPDATE: begin
            sum_in            = sum_ff - SUM_W'(old_val) + SUM_W'(interval_ff);
            valid_in[slot_ff] = 1'b1;
            slot_in           = (slot_ff == SLOT_W'(WINDOW - 1)) ? '0 : slot_ff + 1'b1;
            cnt_in            = cnt_next;
            num_in            = NUM_W'(MS_Q8) * NUM_W'(cnt_next);
            rem_in            = '0;
            quo_in            = '0;
            div_cnt_in        = DIV_CNT_W'(NUM_W - 1);
            state_in          = S_DIV;
         end
         S_DIV: begin
            // one quotient bit per cycle, msb first
            rem_in     = rem_ge ? SUM_W'(rem_shift - {1'b0, sum_ff}) : SUM_W'(rem_shift);
            quo_in     = {quo_ff[NUM_W-2:0], rem_ge};
            num_in     = {num_ff[NUM_W-2:0], 1'b0};
            div_cnt_in = div_cnt_ff - 1'b1;
            if (div_cnt_ff == '0) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               if (op_ff == OP_START) begin
                  rsp_rate_in = '0;
                  rsp_used_in = '0;
                  rsp_sat_in  = 1'b0;
               end else begin
                  rsp_rate_in = res_sat ? RATE_MAX : RATE_W'(quo_ff);
                  rsp_used_in = USED_W'(cnt_ff);
                  rsp_sat_in  = res_sat;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         slot_ff      <= '0;
         cnt_ff       <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         slot_ff      <= slot_in;
         cnt_ff       <= cnt_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      interval_ff <= interval_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      div_cnt_ff  <= div_cnt_in;
      rsp_rate_ff <= rsp_rate_in;
      rsp_used_ff <= rsp_used_in;
      rsp_sat_ff  <= rsp_sat_in;
   end

   // interval ring, registered read of the slot about to be overwritten
   always_ff @(posedge clock) begin
      if (state_ff == S_READ) begin
         rd_data_ff <= ring_mem[slot_ff];
      end
      if (state_ff == S_UPDATE) begin
         ring_mem[slot_ff] <= interval_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_rate  = rsp_rate_ff;
   assign rsp_used  = rsp_used_ff;
   assign rsp_sat   = rsp_sat_ff;

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(WINDOW))
      else $error("fill count above window");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= SLOT_W'(WINDOW - 1))
      else $error("write slot out of range");

   a_clear_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |=> (sum_ff == '0 && cnt_ff == '0 && valid_ff == '0))
      else $error("history not cleared after start word");

   a_pop_route: assert property (@(posedge clock) disable iff (reset)
      (pop_valid && pop_ready) |=> (state_ff == S_CLEAR || state_ff == S_READ))
      else $error("popped word not taken into work");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("response raised outside done state");

endmodule
`default_nettype wire

@@ tb/sv/tb_frame_rate_window_meter.sv @@
// ----------------------------------------------------------------------------
// tb_frame_rate_window_meter
// Self-checking bench for the moving-average frame rate meter. Start and
// frame words are streamed in with random gaps while the response side
// stalls at random. Every response is compared with a behavioral model of
// the interval window and the q8 rate division.
// ----------------------------------------------------------------------------
module tb_frame_rate_window_meter;
   timeunit 1ns;
   timeprecision 1ps;
   import frwm_pkg::*;

   localparam int WIN      = WINDOW_DEF;
   localparam int TAIL_CYC = 40;   // idle tail after all responses are checked

   typedef struct {
      logic [RATE_W-1:0] rate;
      logic [USED_W-1:0] used;
      logic              sat;
   } reading_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [TDATA_IN_W-1:0]  req_tdata;    // timestamp_ms[31:0]
   logic                   req_tuser;    // op
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [TDATA_OUT_W-1:0] rsp_tdata;    // rate_q8[21:0], samples_used[25:22]
   logic                   rsp_tuser;    // saturated

   frame_rate_window_meter #(.WINDOW(WIN)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // model of the meter state
   logic [TS_W-1:0]   prev_stamp;
   logic [TS_W-1:0]   gap_ring [WIN];
   int                ring_slot;
   int                ring_fill;
   longint unsigned   ring_total;

   reading_type       pending_readings [$];
   int                errors;
   int                words_sent;
   int                starts_sent;
   int                readings_checked;
   int                saturated_seen;
   bit                idle_on;
   bit                stall_on;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void clear_history();
      foreach (gap_ring[i]) gap_ring[i] = '0;
      ring_slot  = 0;
      ring_fill  = 0;
      ring_total = 0;
   endfunction

   function automatic reading_type predict_reading(logic op, logic [TS_W-1:0] stamp);
      reading_type       r;
      logic [TS_W-1:0]   gap;
      longint unsigned   q;
      r.rate = '0;
      r.used = '0;
      r.sat  = 1'b0;
      if (op == OP_START) begin
         prev_stamp = stamp;
         clear_history();
         return r;
      end
      gap        = stamp - prev_stamp;
      prev_stamp = stamp;
      ring_total = ring_total - gap_ring[ring_slot] + gap;
      gap_ring[ring_slot] = gap;
      ring_slot  = (ring_slot + 1 == WIN) ? 0 : ring_slot + 1;
      if (ring_fill < WIN) ring_fill++;
      r.used = USED_W'(ring_fill);
      if (ring_total == 0) begin
         r.rate = RATE_MAX;
         r.sat  = 1'b1;
      end else begin
         q = (longint'(MS_Q8) * longint'(ring_fill)) / ring_total;
         if (q > RATE_MAX) begin
            r.rate = RATE_MAX;
            r.sat  = 1'b1;
         end else begin
            r.rate = q[RATE_W-1:0];
         end
      end
      return r;
   endfunction

   // one word on the request side; valid stays high after the handshake so
   // that a following word with no gap goes out back to back
   task automatic send_word(input logic op, input logic [TS_W-1:0] stamp);
      int gap;
      gap = idle_on ? $urandom_range(0, 9) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = op;
      req_tdata  = stamp;
      do @(posedge clock); while (!req_tready);
      pending_readings.push_back(predict_reading(op, stamp));
      words_sent++;
      if (op == OP_START) starts_sent++;
   endtask

   task automatic idle_input();
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic wait_for_readings();
      idle_input();
      while (pending_readings.size() != 0) @(posedge clock);
   endtask

   // response side: either ready waits in advance, or it holds off for a
   // while once a word is offered
   initial begin
      int stall;
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         stall = stall_on ? $urandom_range(0, 9) : 0;
         if (stall > 0) begin
            rsp_tready = 1'b0;
            do @(posedge clock); while (!rsp_tvalid);
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   // capture at the rising edge, compare on the falling edge
   logic                   got_word;
   logic [TDATA_OUT_W-1:0] got_data;
   logic                   got_sat;

   always @(posedge clock) begin
      got_word <= !reset && rsp_tvalid && rsp_tready;
      got_data <= rsp_tdata;
      got_sat  <= rsp_tuser;
   end

   always @(negedge clock) begin : check_readings
      reading_type       want;
      logic [RATE_W-1:0] got_rate;
      logic [USED_W-1:0] got_used;
      got_rate = got_data[RATE_W-1:0];
      got_used = got_data[RATE_W +: USED_W];
      if (got_word === 1'b1) begin
         if (pending_readings.size() == 0) begin
            $error("unexpected word: rate_q8=%0d samples_used=%0d saturated=%0b",
                   got_rate, got_used, got_sat);
            errors++;
         end else begin
            want = pending_readings.pop_front();
            readings_checked++;
            if (got_sat) saturated_seen++;
            if (got_rate !== want.rate) begin
               $error("rate_q8: expected %0d, got %0d", want.rate, got_rate);
               errors++;
            end
            if (got_used !== want.used) begin
               $error("samples_used: expected %0d, got %0d", want.used, got_used);
               errors++;
            end
            if (got_sat !== want.sat) begin
               $error("saturated: expected %0b, got %0b", want.sat, got_sat);
               errors++;
            end
         end
      end
   end

   // right out of reset the reference time is zero
   task automatic test_frame_before_start();
      send_word(OP_FRAME, 32'd40);
      send_word(OP_FRAME, 32'd40);
   endtask

   // warm-up count, timestamp wrap past 2^32 and ring wraparound
   task automatic test_warmup_and_wrap();
      logic [TS_W-1:0] stamp;
      stamp = 32'hFFFF_FFF0;
      send_word(OP_START, stamp);
      repeat (WIN + 1) begin
         stamp += 32'd16;
         send_word(OP_FRAME, stamp);
      end
   endtask

   task automatic test_zero_sum();
      send_word(OP_START, 32'd1000);
      send_word(OP_FRAME, 32'd1000);
      send_word(OP_FRAME, 32'd1000);
      send_word(OP_FRAME, 32'd1001);
   endtask

   // largest interval, then a timestamp going backwards
   task automatic test_extreme_intervals();
      send_word(OP_START, 32'd0);
      send_word(OP_FRAME, 32'hFFFF_FFFF);
      send_word(OP_FRAME, 32'hFFFF_FFFE);
      send_word(OP_FRAME, 32'd5);
   endtask

   task automatic test_drain_pause();
      idle_on = 1'b0;
      send_word(OP_START, 32'd500);
      send_word(OP_FRAME, 32'd533);
      wait_for_readings();
      send_word(OP_FRAME, 32'd566);
      idle_on = 1'b1;
   endtask

   // mostly start-then-frames runs with realistic intervals, plus noise
   // and runs of repeated timestamps
   task automatic test_random_runs(input int target);
      int              stop_at;
      int              kind;
      int              pick;
      logic [TS_W-1:0] stamp;
      logic [TS_W-1:0] step;
      stop_at = words_sent + target;
      while (words_sent < stop_at) begin
         kind     = $urandom_range(0, 9);
         idle_on  = ($urandom_range(0, 3) != 0);
         stall_on = ($urandom_range(0, 3) != 0);
         if (kind <= 6) begin
            stamp = $urandom();
            send_word(OP_START, stamp);
            repeat ($urandom_range(1, 30)) begin
               pick = $urandom_range(0, 19);
               if (pick < 2)       step = '0;
               else if (pick < 15) step = $urandom_range(8, 50);
               else if (pick < 18) step = $urandom_range(51, 2000);
               else if (pick < 19) step = $urandom_range(2001, 1_000_000);
               else                step = $urandom();
               stamp += step;
               send_word(OP_FRAME, stamp);
            end
         end else if (kind <= 8) begin
            repeat ($urandom_range(1, 6))
               send_word($urandom_range(0, 1) ? OP_FRAME : OP_START, $urandom());
         end else begin
            stamp = $urandom();
            send_word(OP_START, stamp);
            repeat ($urandom_range(1, 12)) send_word(OP_FRAME, stamp);
            repeat ($urandom_range(0, 4)) begin
               stamp += $urandom_range(1, 40);
               send_word(OP_FRAME, stamp);
            end
         end
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = OP_START;
      errors           = 0;
      words_sent       = 0;
      starts_sent      = 0;
      readings_checked = 0;
      saturated_seen   = 0;
      idle_on          = 1'b1;
      stall_on         = 1'b1;
      prev_stamp       = '0;
      clear_history();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_frame_before_start();
      test_warmup_and_wrap();
      test_zero_sum();
      test_extreme_intervals();
      test_drain_pause();
      test_random_runs(1230);

      wait_for_readings();
      repeat (TAIL_CYC) @(posedge clock);
      $display("run covered %0d words (%0d start, %0d frame), %0d responses checked",
               words_sent, starts_sent, words_sent - starts_sent, readings_checked);
      $display("  %0d of them saturated on a zero interval sum", saturated_seen);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout with %0d responses outstanding", pending_readings.size());
      $display("DONE: errors detected");
      $finish;
   end

endmodule
